>>> hdl/vfd_pkg.sv
// Shared types, codes, glyph table and segment layout functions for the VFD frame builder.
package vfd_pkg;

  localparam int IMAGE_BYTES_DEF = 16;

  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_CHAR    = 3'd1;
  localparam logic [2:0] KIND_COLON   = 3'd2;
  localparam logic [2:0] KIND_ICON    = 3'd3;
  localparam logic [2:0] KIND_REFRESH = 3'd4;

  localparam logic [2:0] POS_DIGIT0 = 3'd0;
  localparam logic [2:0] POS_DIGIT1 = 3'd1;
  localparam logic [2:0] POS_DIGIT2 = 3'd2;
  localparam logic [2:0] POS_DIGIT3 = 3'd3;
  localparam logic [2:0] POS_DIGIT4 = 3'd4;
  localparam logic [2:0] POS_DIGIT5 = 3'd5;

  localparam int BYTE_DIGIT0 = 0;
  localparam int BYTE_DIGIT1 = 3;
  localparam int BYTE_DIGIT2 = 9;
  localparam int BYTE_DIGIT3 = 15;
  localparam int BYTE_SHARED12 = 12;
  localparam int BYTE_SHARED13 = 13;
  localparam int BYTE_DIGIT5_LO = 14;

  localparam logic [7:0] CMD_MODE = 8'h02;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_ON   = 8'h88;
  localparam logic [7:0] BRIGHT_MAX = 8'd7;

  localparam logic [7:0] KEEP12_DIGIT4 = 8'h05;
  localparam logic [7:0] KEEP13_DIGIT4 = 8'hCF;
  localparam logic [7:0] KEEP13_DIGIT5 = 8'h3F;
  localparam logic [7:0] KEEP12_COLON  = 8'hFA;
  localparam logic [7:0] KEEP13_ICON   = 8'hF0;

  localparam logic [7:0] NO_GLYPH    = 8'hFF;
  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;

  localparam logic [7:0] GLYPH_ROM [0:94] = '{
    8'h00, 8'hFF, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
    8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'hFF, 8'hFF,
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'h09, 8'hFF, 8'h65,
    8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
    8'h67, 8'h75, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
    8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
    8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
    8'h67, 8'h75, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
    8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
  };

  typedef struct packed {
    logic       apply;
    logic       load;
    logic [4:0] idx;
  } vfd_cmd_t;

  typedef struct packed {
    logic out_hold;
  } vfd_status_t;

  // Glyph segments are A..G at bits 6..0; bit 7 set means no glyph.
  function automatic logic [7:0] glyph_lookup(input logic [7:0] ch);
    logic [7:0] off;
    off = ch - GLYPH_FIRST;
    if (ch < GLYPH_FIRST || ch > GLYPH_LAST) begin
      return NO_GLYPH;
    end
    return GLYPH_ROM[off[6:0]];
  endfunction

  function automatic logic [7:0] layout_standard(input logic [7:0] g);
    return {1'b0, g[6], g[5], g[1], g[0], g[4], g[2], g[3]};
  endfunction

endpackage

>>> hdl/vfd_ctrl.sv
// Controller state machine: accepts requests and sequences the refresh frame.
module vfd_ctrl #(
  parameter int IMAGE_BYTES = vfd_pkg::IMAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [2:0]          in_kind,
  output logic                in_tready,
  input  vfd_pkg::vfd_status_t status,
  output vfd_pkg::vfd_cmd_t   cmd
);

  localparam int FRAME_LEN = IMAGE_BYTES + 3;
  localparam int CW = $clog2(FRAME_LEN);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          accept;
  logic          load;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load      = (state_r == ST_EMIT) && !status.out_hold;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == vfd_pkg::KIND_REFRESH) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (cnt_r == CW'(FRAME_LEN - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cmd.apply = accept && (in_kind != vfd_pkg::KIND_REFRESH);
  assign cmd.load  = load;
  assign cmd.idx   = 5'(cnt_r);

endmodule

>>> hdl/vfd_datapath.sv
// Datapath: display image registers, brightness register and frame output register.
module vfd_datapath #(
  parameter int IMAGE_BYTES = vfd_pkg::IMAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vfd_pkg::vfd_cmd_t    cmd,
  output vfd_pkg::vfd_status_t status,
  input  logic [2:0]           in_kind,
  input  logic [2:0]           in_position,
  input  logic [7:0]           in_character,
  input  logic                 in_colon_top,
  input  logic                 in_colon_bottom,
  input  logic [3:0]           in_icon_bits,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [7:0]           out_frame_byte,
  output logic                 out_strobe_end,
  output logic                 out_last
);

  localparam int FRAME_LEN = IMAGE_BYTES + 3;
  localparam int AW = $clog2(IMAGE_BYTES);

  logic [7:0] image_r [IMAGE_BYTES];
  logic [7:0] image_nxt [IMAGE_BYTES];
  logic [7:0] bright_r;
  logic [7:0] glyph;
  logic [7:0] lay;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_strobe_r, out_strobe_nxt;
  logic       out_last_r, out_last_nxt;
  logic [4:0] img_off;
  logic [2:0] bright_sat;

  assign glyph = vfd_pkg::glyph_lookup(in_character);
  assign lay   = vfd_pkg::layout_standard(glyph);

  always_comb begin
    image_nxt = image_r;
    if (cmd.apply) begin
      unique case (in_kind)
        vfd_pkg::KIND_CLEAR: begin
          for (int i = 0; i < IMAGE_BYTES; i++) begin
            image_nxt[i] = '0;
          end
        end
        vfd_pkg::KIND_CHAR: begin
          if (!glyph[7]) begin
            unique case (in_position)
              vfd_pkg::POS_DIGIT0: image_nxt[vfd_pkg::BYTE_DIGIT0] = lay;
              vfd_pkg::POS_DIGIT1: image_nxt[vfd_pkg::BYTE_DIGIT1] = lay;
              vfd_pkg::POS_DIGIT2: image_nxt[vfd_pkg::BYTE_DIGIT2] = lay;
              vfd_pkg::POS_DIGIT3: image_nxt[vfd_pkg::BYTE_DIGIT3] = lay;
              vfd_pkg::POS_DIGIT4: begin
                image_nxt[vfd_pkg::BYTE_SHARED12] =
                  (image_r[vfd_pkg::BYTE_SHARED12] & vfd_pkg::KEEP12_DIGIT4) |
                  {1'b0, glyph[6], glyph[5], glyph[1], glyph[0], 1'b0, glyph[2], 1'b0};
                image_nxt[vfd_pkg::BYTE_SHARED13] =
                  (image_r[vfd_pkg::BYTE_SHARED13] & vfd_pkg::KEEP13_DIGIT4) |
                  {2'b00, glyph[4], glyph[3], 4'b0000};
              end
              vfd_pkg::POS_DIGIT5: begin
                image_nxt[vfd_pkg::BYTE_SHARED13] =
                  (image_r[vfd_pkg::BYTE_SHARED13] & vfd_pkg::KEEP13_DIGIT5) |
                  {glyph[6], glyph[1], 6'b000000};
                image_nxt[vfd_pkg::BYTE_DIGIT5_LO] =
                  {3'b000, glyph[5], glyph[0], glyph[4], glyph[3], glyph[2]};
              end
              default: ;
            endcase
          end
        end
        vfd_pkg::KIND_COLON: begin
          image_nxt[vfd_pkg::BYTE_SHARED12] =
            (image_r[vfd_pkg::BYTE_SHARED12] & vfd_pkg::KEEP12_COLON) |
            {5'b00000, in_colon_top, 1'b0, in_colon_bottom};
        end
        vfd_pkg::KIND_ICON: begin
          image_nxt[vfd_pkg::BYTE_SHARED13] =
            (image_r[vfd_pkg::BYTE_SHARED13] & vfd_pkg::KEEP13_ICON) |
            {4'b0000, in_icon_bits};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IMAGE_BYTES; i++) begin
        image_r[i] <= '0;
      end
      bright_r <= vfd_pkg::BRIGHT_MAX;
    end else begin
      image_r <= image_nxt;
      if (cfg_wr_en) begin
        bright_r <= cfg_wr_data;
      end
    end
  end

  assign img_off    = cmd.idx - 5'd2;
  assign bright_sat = (bright_r > vfd_pkg::BRIGHT_MAX) ? 3'd7 : bright_r[2:0];

  always_comb begin
    out_byte_nxt   = out_byte_r;
    out_strobe_nxt = out_strobe_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (cmd.load) begin
      out_valid_nxt  = 1'b1;
      out_strobe_nxt = 1'b0;
      out_last_nxt   = 1'b0;
      priority if (cmd.idx == 5'd0) begin
        out_byte_nxt   = vfd_pkg::CMD_MODE;
        out_strobe_nxt = 1'b1;
      end else if (cmd.idx == 5'd1) begin
        out_byte_nxt = vfd_pkg::CMD_ADDR;
      end else if (cmd.idx == 5'(FRAME_LEN - 1)) begin
        out_byte_nxt   = vfd_pkg::CMD_ON | {5'b00000, bright_sat};
        out_strobe_nxt = 1'b1;
        out_last_nxt   = 1'b1;
      end else begin
        out_byte_nxt   = image_r[img_off[AW-1:0]];
        out_strobe_nxt = (cmd.idx == 5'(FRAME_LEN - 2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r   <= out_byte_nxt;
    out_strobe_r <= out_strobe_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign status.out_hold = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_strobe_end  = out_strobe_r;
  assign out_last        = out_last_r;

endmodule

>>> hdl/vfd_segment_frame_builder_top.sv
// Top level of the VFD segment frame builder.
// The in_ stream carries requests: tuser selects clear, character, colon, icons or
// refresh, and tdata carries the position, character code, colon dots and icon bits.
// Clear, character, colon and icon requests update the display image at the
// accepting edge; they produce no output.
// A refresh request produces 19 bytes on the out_ stream: the mode command, the
// address command with the 16 image bytes, and the display-on command with the
// brightness clipped to 7. After the request is accepted the controller enters its
// emit state, and from there the bytes are loaded into the output register, one byte
// per cycle while out_tready is high, paced by the controller's frame byte counter.
// in_tready is low while the frame is being produced and returns high once the last
// byte is loaded into the output register, so the next request can be accepted
// while that byte still waits. When the receiver stalls, the output register holds
// its byte and the counter waits. out_tuser marks a byte after which strobe rises,
// and out_tlast marks the final byte of the frame.
// Brightness is written through cfg_wr_en and cfg_wr_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Synchronous reset clears the image, sets brightness to 7 and empties the output.
module vfd_segment_frame_builder_top #(
  parameter int IMAGE_BYTES = vfd_pkg::IMAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // position[2:0], character[10:3], colon_top[11], colon_bottom[12], icon_bits[16:13]
  input  logic [23:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_byte[7:0]
  output logic [7:0]  out_tdata,
  // strobe_end[0]
  output logic        out_tuser,
  output logic        out_tlast
);

  vfd_pkg::vfd_cmd_t    cmd;
  vfd_pkg::vfd_status_t status;

  vfd_ctrl #(.IMAGE_BYTES(IMAGE_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vfd_datapath #(.IMAGE_BYTES(IMAGE_BYTES)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_tuser),
    .in_position     (in_tdata[2:0]),
    .in_character    (in_tdata[10:3]),
    .in_colon_top    (in_tdata[11]),
    .in_colon_bottom (in_tdata[12]),
    .in_icon_bits    (in_tdata[16:13]),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_frame_byte  (out_tdata),
    .out_strobe_end  (out_tuser),
    .out_last        (out_tlast)
  );

endmodule

>>> hdl/vfd_checker.sv
// Port-level checker for the VFD frame builder and its bind to the top level.
module vfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_refresh_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == vfd_pkg::KIND_REFRESH |=> !in_tready)
    else $error("input accepted right after a refresh request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output byte changed");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser && out_tdata[7:3] == vfd_pkg::CMD_ON[7:3])
    else $error("final frame byte is not a strobed display-on command");

  a_idle_only_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tready |-> out_tlast)
    else $error("ready for requests while the frame is unfinished");

endmodule

bind vfd_segment_frame_builder_top vfd_checker u_vfd_checker (.*);

>>> dv/vfd_segment_frame_builder_top_tb.sv
// Self-checking testbench for the VFD segment frame builder: directed table, then random requests.
module vfd_segment_frame_builder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [2:0] POS_NONE_LO = 3'd6;
  localparam logic [2:0] POS_NONE_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PHASES = 6;

  localparam logic [7:0] GLYPH_TABLE [0:94] = '{
    8'h00, 8'hFF, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
    8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'hFF, 8'hFF,
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'h09, 8'hFF, 8'h65,
    8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
    8'h67, 8'h75, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
    8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
    8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
    8'h67, 8'h75, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
    8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
  };

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] pos;
    logic [7:0] ch;
    logic       top;
    logic       bot;
    logic [3:0] icon;
  } request_t;

  typedef struct packed {
    request_t   req;
    logic       typed;
    logic [7:0] on_byte;
  } script_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       strobe_end;
    logic       last;
  } frame_byte_t;

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{'{vfd_pkg::KIND_REFRESH, 3'd0, 8'h00, 1'b0, 1'b0, 4'h0}, 1'b1, 8'h8F},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT0, 8'h38, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT1, 8'h20, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT2, 8'h7E, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT3, 8'h1F, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT3, 8'h7F, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT4, 8'h38, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT5, 8'h38, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, POS_NONE_LO, 8'h38, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, POS_NONE_HI, 8'hFF, 1'b1, 1'b1, 4'hF}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT0, 8'h21, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_REFRESH, 3'd0, 8'h00, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_COLON, 3'd0, 8'h00, 1'b1, 1'b1, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_ICON, 3'd0, 8'h00, 1'b0, 1'b0, 4'hF}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT4, 8'h31, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CHAR, vfd_pkg::POS_DIGIT5, 8'h20, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_REFRESH, 3'd0, 8'h00, 1'b0, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_COLON, 3'd0, 8'h00, 1'b1, 1'b0, 4'h0}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_ICON, 3'd0, 8'h00, 1'b0, 1'b0, 4'h5}, 1'b0, 8'h00},
    '{'{KIND_UNUSED_LO, 3'd7, 8'hFF, 1'b1, 1'b1, 4'hF}, 1'b0, 8'h00},
    '{'{KIND_UNUSED_HI, 3'd7, 8'hFF, 1'b1, 1'b1, 4'hF}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_REFRESH, 3'd7, 8'hFF, 1'b1, 1'b1, 4'hF}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_CLEAR, 3'd7, 8'hFF, 1'b1, 1'b1, 4'hF}, 1'b0, 8'h00},
    '{'{vfd_pkg::KIND_REFRESH, 3'd0, 8'h00, 1'b0, 1'b0, 4'h0}, 1'b1, 8'h8F}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [7:0]  image_model [vfd_pkg::IMAGE_BYTES_DEF];
  logic [7:0]  brightness_model;
  frame_byte_t pending_bytes [$];
  int          fail_count = 0;
  bit          calm = 1'b0;
  int          ready_hold = 0;

  vfd_segment_frame_builder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] glyph_of(input logic [7:0] ch);
    if (ch < 8'h20 || ch > 8'h7E) begin
      return vfd_pkg::NO_GLYPH;
    end
    return GLYPH_TABLE[ch - 8'h20];
  endfunction

  // Glyph bits 6..0 are segments A B C D E F G.
  function automatic logic [7:0] digit_byte(input logic [7:0] g);
    return {1'b0, g[6], g[5], g[1], g[0], g[4], g[2], g[3]};
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic se, input logic lst);
    frame_byte_t fb;
    fb.data = b;
    fb.strobe_end = se;
    fb.last = lst;
    pending_bytes.push_back(fb);
  endfunction

  function automatic void apply_request(input request_t r);
    logic [7:0] g;
    logic [2:0] level;
    case (r.kind)
      vfd_pkg::KIND_CLEAR: begin
        foreach (image_model[i]) image_model[i] = '0;
      end
      vfd_pkg::KIND_CHAR: begin
        g = glyph_of(r.ch);
        if (!g[7]) begin
          case (r.pos)
            vfd_pkg::POS_DIGIT0: image_model[vfd_pkg::BYTE_DIGIT0] = digit_byte(g);
            vfd_pkg::POS_DIGIT1: image_model[vfd_pkg::BYTE_DIGIT1] = digit_byte(g);
            vfd_pkg::POS_DIGIT2: image_model[vfd_pkg::BYTE_DIGIT2] = digit_byte(g);
            vfd_pkg::POS_DIGIT3: image_model[vfd_pkg::BYTE_DIGIT3] = digit_byte(g);
            vfd_pkg::POS_DIGIT4: begin
              image_model[vfd_pkg::BYTE_SHARED12] = {1'b0, g[6], g[5], g[1], g[0],
                image_model[vfd_pkg::BYTE_SHARED12][2], g[2],
                image_model[vfd_pkg::BYTE_SHARED12][0]};
              image_model[vfd_pkg::BYTE_SHARED13] = {
                image_model[vfd_pkg::BYTE_SHARED13][7:6], g[4], g[3],
                image_model[vfd_pkg::BYTE_SHARED13][3:0]};
            end
            vfd_pkg::POS_DIGIT5: begin
              image_model[vfd_pkg::BYTE_SHARED13] = {g[6], g[1],
                image_model[vfd_pkg::BYTE_SHARED13][5:0]};
              image_model[vfd_pkg::BYTE_DIGIT5_LO] = {3'b000, g[5], g[0], g[4], g[3], g[2]};
            end
            default: ;
          endcase
        end
      end
      vfd_pkg::KIND_COLON: begin
        image_model[vfd_pkg::BYTE_SHARED12] = {image_model[vfd_pkg::BYTE_SHARED12][7:3],
          r.top, image_model[vfd_pkg::BYTE_SHARED12][1], r.bot};
      end
      vfd_pkg::KIND_ICON: begin
        image_model[vfd_pkg::BYTE_SHARED13] = {image_model[vfd_pkg::BYTE_SHARED13][7:4],
          r.icon};
      end
      vfd_pkg::KIND_REFRESH: begin
        queue_byte(vfd_pkg::CMD_MODE, 1'b1, 1'b0);
        queue_byte(vfd_pkg::CMD_ADDR, 1'b0, 1'b0);
        foreach (image_model[i]) begin
          queue_byte(image_model[i], i == vfd_pkg::IMAGE_BYTES_DEF - 1, 1'b0);
        end
        level = (brightness_model > 8'd7) ? 3'd7 : brightness_model[2:0];
        queue_byte(vfd_pkg::CMD_ON | {5'b00000, level}, 1'b1, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.pos = 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) r.pos = 3'($urandom_range(POS_NONE_LO, POS_NONE_HI));
    r.ch = 8'($urandom_range(8'h20, 8'h7E));
    if ($urandom_range(0, 6) == 0) r.ch = 8'($urandom_range(0, 255));
    r.top = 1'($urandom_range(0, 1));
    r.bot = 1'($urandom_range(0, 1));
    r.icon = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 5) r.kind = vfd_pkg::KIND_CLEAR;
    else if (pick < 50) r.kind = vfd_pkg::KIND_CHAR;
    else if (pick < 60) r.kind = vfd_pkg::KIND_COLON;
    else if (pick < 70) r.kind = vfd_pkg::KIND_ICON;
    else if (pick < 93) r.kind = vfd_pkg::KIND_REFRESH;
    else r.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    return r;
  endfunction

  // Offers one request, with an occasional idle burst first, and returns at its accepting edge.
  task automatic send_request(input request_t r);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {7'b0000000, r.icon, r.bot, r.top, r.ch, r.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_frames();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [7:0] level);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    brightness_model = level;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_tdata !== want.data) begin
          $display("%0t: frame byte mismatch, expected %h, actual %h", $time, want.data,
                   out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.strobe_end) begin
          $display("%0t: strobe_end mismatch, expected %b, actual %b", $time, want.strobe_end,
                   out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, out_tlast);
          fail_count++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    logic [7:0] levels [PHASES];
    int waited;
    levels = '{8'd0, 8'd255, 8'd8, 8'd7, 8'd0, 8'd1};
    levels[4] = 8'($urandom_range(0, 255));
    foreach (image_model[i]) image_model[i] = '0;
    brightness_model = 8'd7;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_request(SCRIPT[i].req);
      if (SCRIPT[i].typed) begin
        queue_byte(vfd_pkg::CMD_MODE, 1'b1, 1'b0);
        queue_byte(vfd_pkg::CMD_ADDR, 1'b0, 1'b0);
        for (int k = 0; k < vfd_pkg::IMAGE_BYTES_DEF; k++) begin
          queue_byte(8'h00, k == vfd_pkg::IMAGE_BYTES_DEF - 1, 1'b0);
        end
        queue_byte(SCRIPT[i].on_byte, 1'b1, 1'b1);
      end else begin
        apply_request(SCRIPT[i].req);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_frames();
      set_brightness(levels[p]);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        request_t r;
        r = random_request();
        send_request(r);
        apply_request(r);
      end
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d frame bytes never arrived, expected %h first, actual none", $time,
               pending_bytes.size(), pending_bytes[0].data);
      fail_count++;
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/vfd_pkg.sv
hdl/vfd_ctrl.sv
hdl/vfd_datapath.sv
hdl/vfd_segment_frame_builder_top.sv
hdl/vfd_checker.sv
dv/vfd_segment_frame_builder_top_tb.sv
